FILE: hdl/imd_pkg.sv
// Shared types and constants for the insulation monitor PWM status decoder.
// Depends on nothing; the front end, back end and top level refer to it by scoped names.
`default_nettype none

package imd_pkg;

	typedef enum logic [2:0] {
		COND_SHORT        = 3'd0,
		COND_NORMAL       = 3'd1,
		COND_UNDERVOLTAGE = 3'd2,
		COND_SPEED_START  = 3'd3,
		COND_DEVICE_ERROR = 3'd4,
		COND_GROUND_FAULT = 3'd5,
		COND_INVALID      = 3'd6
	} cond_t;

	typedef struct packed {
		logic [15:0] pwm_freq;
		logic [13:0] pwm_duty;
	} in_item_t;

	typedef struct packed {
		cond_t       condition;
		logic        duty_ok;
		logic [15:0] insulation_kohm;
		logic        start_bad;
	} out_item_t;

	// classified item handed from the front end to the divider back end
	typedef struct packed {
		cond_t       condition;
		logic        duty_ok;
		logic        start_bad;
		logic        kohm_en;
		logic        kohm_sat;
		logic [13:0] divisor;
	} mid_item_t;

	// APB register indexes
	localparam logic REG_FREQ_TOLERANCE = 1'b0;

	localparam logic [7:0] TOL_RESET = 8'd32;

	localparam int          WINDOW_COUNT = 6;
	localparam logic [10:0] WINDOW_STEP  = 11'd160;

	localparam logic [13:0] DUTY_KOHM_LO  = 14'd500;
	localparam logic [13:0] DUTY_KOHM_HI  = 14'd9000;
	localparam logic [13:0] DUTY_GOOD_LO  = 14'd500;
	localparam logic [13:0] DUTY_GOOD_HI  = 14'd1000;
	localparam logic [13:0] DUTY_BAD_LO   = 14'd9000;
	localparam logic [13:0] DUTY_BAD_HI   = 14'd9500;
	localparam logic [13:0] DUTY_FAULT_LO = 14'd4750;
	localparam logic [13:0] DUTY_FAULT_HI = 14'd5250;
	// 10800000/(D-500) exceeds 51200 (saturated output) exactly when D <= 710
	localparam logic [13:0] DUTY_SAT_MAX  = 14'd710;

	localparam logic [23:0] KOHM_NUMERATOR = 24'd10800000;
	localparam logic [15:0] KOHM_OFFSET    = 16'd1200;
	localparam logic [15:0] KOHM_MAX       = 16'd50000;

	// restoring divider: 16 quotient bits, two per stage
	localparam int DIV_QBITS      = 16;
	localparam int DIV_BITS_STAGE = 2;
	localparam int DIV_STAGES     = DIV_QBITS / DIV_BITS_STAGE;

endpackage

`default_nettype wire

FILE: hdl/imd_fifo.sv
// Small register-based FIFO used between the decoder sections.
// Generic payload vector; no package dependency. DEPTH must be at least 2.
`default_nettype none

module imd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/imd_front.sv
// Front end: APB tolerance register, frequency window match and duty checks.
// Depends on imd_pkg.
`default_nettype none

module imd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire imd_pkg::in_item_t item,
	output imd_pkg::mid_item_t     cls
);

	logic [7:0]  tol_q;
	logic [10:0] ideal, lo, hi;
	logic        found;
	logic [15:0] f;
	logic [13:0] d;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == imd_pkg::REG_FREQ_TOLERANCE) ? {24'd0, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= imd_pkg::TOL_RESET;
		end else if (psel && penable && pwrite
				&& paddr[2] == imd_pkg::REG_FREQ_TOLERANCE) begin
			tol_q <= pwdata[7:0];
		end
	end

	always_comb begin
		f     = item.pwm_freq;
		d     = item.pwm_duty;
		found = 1'b0;
		ideal = '0;
		lo    = '0;
		hi    = '0;
		cls   = '0;
		cls.condition = imd_pkg::COND_INVALID;

		// lowest ideal frequency wins when windows overlap
		for (int i = 0; i < imd_pkg::WINDOW_COUNT; i++) begin
			ideal = 11'(i) * imd_pkg::WINDOW_STEP;
			lo    = (ideal > {3'd0, tol_q}) ? ideal - {3'd0, tol_q} : 11'd0;
			hi    = ideal + {3'd0, tol_q};
			if (!found && f >= {5'd0, lo} && f <= {5'd0, hi}) begin
				found         = 1'b1;
				cls.condition = imd_pkg::cond_t'(3'(i));
			end
		end

		cls.divisor  = d - imd_pkg::DUTY_KOHM_LO;
		cls.kohm_sat = (d <= imd_pkg::DUTY_SAT_MAX);

		case (cls.condition)
			imd_pkg::COND_SHORT: begin
				cls.duty_ok = 1'b1;
			end
			imd_pkg::COND_NORMAL, imd_pkg::COND_UNDERVOLTAGE: begin
				cls.duty_ok = (d >= imd_pkg::DUTY_KOHM_LO && d <= imd_pkg::DUTY_KOHM_HI);
				cls.kohm_en = cls.duty_ok;
			end
			imd_pkg::COND_SPEED_START: begin
				if (d >= imd_pkg::DUTY_GOOD_LO && d <= imd_pkg::DUTY_GOOD_HI) begin
					cls.duty_ok = 1'b1;
				end else if (d >= imd_pkg::DUTY_BAD_LO && d <= imd_pkg::DUTY_BAD_HI) begin
					cls.duty_ok   = 1'b1;
					cls.start_bad = 1'b1;
				end
			end
			imd_pkg::COND_DEVICE_ERROR, imd_pkg::COND_GROUND_FAULT: begin
				cls.duty_ok = (d >= imd_pkg::DUTY_FAULT_LO && d <= imd_pkg::DUTY_FAULT_HI);
			end
			default: begin
				cls.duty_ok = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/imd_back.sv
// Back end: pipelined restoring divider for the resistance, credit-based issue
// and the result FIFO. Depends on imd_pkg and imd_fifo.
`default_nettype none

module imd_back #(
	parameter int OUT_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire imd_pkg::mid_item_t  mid,
	input  wire logic                mid_empty,
	output logic                     mid_pop,
	output imd_pkg::out_item_t       result,
	output logic                     empty,
	input  wire logic                pop
);

	localparam int NS = imd_pkg::DIV_STAGES;
	localparam int CW = $clog2(OUT_DEPTH + 1);

	typedef struct packed {
		imd_pkg::mid_item_t ctl;
		logic [13:0]        rem;
		logic [15:0]        quo;
	} div_stage_t;

	div_stage_t         st_s [NS+1];
	logic [NS:0]        vld_s;
	logic [CW-1:0]      credit_q;
	imd_pkg::out_item_t res;
	logic               out_full;
	logic               pop_acc;

	function automatic div_stage_t div_step(div_stage_t s, int k);
		div_stage_t  r;
		logic [14:0] t;
		r = s;
		for (int b = 0; b < imd_pkg::DIV_BITS_STAGE; b++) begin
			t = {r.rem, imd_pkg::KOHM_NUMERATOR[imd_pkg::DIV_QBITS - 1
				- k * imd_pkg::DIV_BITS_STAGE - b]};
			if (t >= {1'b0, r.ctl.divisor}) begin
				r.rem = 14'(t - {1'b0, r.ctl.divisor});
				r.quo = {r.quo[14:0], 1'b1};
			end else begin
				r.rem = t[13:0];
				r.quo = {r.quo[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	assign pop_acc = pop && !empty;
	// a slot in the result FIFO is reserved for every transaction in flight
	assign mid_pop = !mid_empty && (credit_q < CW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
			vld_s    <= '0;
		end else begin
			credit_q <= credit_q + CW'(mid_pop) - CW'(pop_acc);
			vld_s    <= {vld_s[NS-1:0], mid_pop};
		end
	end

	always_ff @(posedge clk) begin
		st_s[0].ctl <= mid;
		// upper numerator bits are below any divisor that is not saturated
		st_s[0].rem <= 14'(imd_pkg::KOHM_NUMERATOR[23:imd_pkg::DIV_QBITS]);
		st_s[0].quo <= '0;
		for (int k = 0; k < NS; k++) begin
			st_s[k+1] <= div_step(st_s[k], k);
		end
	end

	always_comb begin
		res.condition       = st_s[NS].ctl.condition;
		res.duty_ok         = st_s[NS].ctl.duty_ok;
		res.start_bad       = st_s[NS].ctl.start_bad;
		res.insulation_kohm = '0;
		if (st_s[NS].ctl.kohm_en) begin
			res.insulation_kohm = st_s[NS].ctl.kohm_sat ? imd_pkg::KOHM_MAX
				: st_s[NS].quo - imd_pkg::KOHM_OFFSET;
		end
	end

	imd_fifo #(
		.WIDTH ($bits(imd_pkg::out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (vld_s[NS]),
		.wr_data (res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

	// credits keep the FIFO from overflowing; full is never seen with a write
	logic unused_full;
	assign unused_full = out_full;

endmodule

`default_nettype wire

FILE: hdl/imd_pwm_status_decoder_unit.sv
// Insulation monitor PWM status decoder, top level.
// Input queue port: push/full carries {pwm_freq, pwm_duty}; a transaction is
//   taken when push is high and full is low, one per cycle if the queue allows.
// Result queue port: empty/pop; the oldest result sits on result while empty
//   is low and leaves when pop is high.
// APB port holds the frequency tolerance register at byte address 0
//   (reset 32); write it only while the decoder is idle. pready is tied high.
// Throughput: one transaction per cycle unless the receiver stalls. The front
//   end classifies in the accepting cycle into a MID_DEPTH queue; the back
//   end runs an 8-stage restoring divider (two quotient bits per stage) for
//   the resistance, between a divider input register and the result FIFO.
// If the receiver stalls, results pile up in the OUT_DEPTH result FIFO, issue
//   into the divider stops once every FIFO slot is reserved, then the middle
//   queue fills and full rises. No transaction is dropped.
// Reset clears the queues and the divider valid bits; no clearing pass.
// Depends on imd_pkg, imd_fifo, imd_front and imd_back.
`default_nettype none

module imd_pwm_status_decoder_unit #(
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              push,
	output logic                   full,
	input  wire imd_pkg::in_item_t item,
	output logic                   empty,
	input  wire logic              pop,
	output imd_pkg::out_item_t     result
);

	imd_pkg::mid_item_t cls, mid;
	logic               mid_empty, mid_pop;

	imd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item),
		.cls     (cls)
	);

	imd_fifo #(
		.WIDTH ($bits(imd_pkg::mid_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (mid),
		.empty   (mid_empty)
	);

	imd_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (mid),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire
